[rtl/wav_riff_pkg.sv]
`default_nettype none

package wav_riff_pkg;

   localparam int RSP_QUEUE_DEPTH = 4;

   localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
   localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
   localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
   localparam logic [31:0] TAG_FACT = 32'h6661_6374;
   localparam logic [31:0] TAG_DATA = 32'h6461_7461;

   localparam logic [31:0] FMT_CORE_LEN = 32'd16;
   localparam logic [15:0] EXT_SIZE     = 16'd22;
   localparam logic [33:0] TAIL_MIN     = 34'd8;

   typedef enum logic [3:0] {
      ST_OK       = 4'd0,
      ST_NO_RIFF  = 4'd1,
      ST_SMALL    = 4'd2,
      ST_NO_WAVE  = 4'd3,
      ST_BAD_FMT  = 4'd4,
      ST_TRUNC    = 4'd5,
      ST_NO_FMT   = 4'd6,
      ST_NO_DATA  = 4'd7,
      ST_NEITHER  = 4'd8
   } status_type;

   typedef enum logic {
      KIND_DATA   = 1'b0,
      KIND_STATUS = 1'b1
   } kind_type;

   typedef struct packed {
      logic [31:0] data_length;
      logic [31:0] channel_mask;
      logic [15:0] valid_bits;
      logic [15:0] bits_per_sample;
      logic [15:0] block_align;
      logic [31:0] byte_rate;
      logic [31:0] sample_rate;
      logic [15:0] channels;
      logic [15:0] format_tag;
      status_type  status;
      logic [7:0]  data_byte;
      kind_type    kind;
   } result_type;

   typedef struct packed {
      logic       first_valid;
      logic       second_valid;
      result_type first;
      result_type second;
   } push_type;

endpackage

`default_nettype wire

[rtl/wav_riff_stream_parser.sv]
// Channel   Dir  Handshake             tdata                         tuser / tlast
// req_      in   req_tvalid/tready     byte_in[7:0]                  tlast = last_byte
// rsp_      out  rsp_tvalid/tready     data_byte .. data_length      tuser = kind
//
// One input byte per cycle while req_tready is high; each byte is parsed in the cycle it is taken.
// A byte yields up to two results, held in a small result queue.
// req_tready drops only while the queue has fewer than two free slots.
// Synchronous active-high reset returns the parser to the RIFF header.
`default_nettype none

module wav_riff_stream_parser
   import wav_riff_pkg::*;
#(
   parameter int QueueDepth = RSP_QUEUE_DEPTH
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [7:0]   req_tdata,   // byte_in[7:0]
   input  wire logic         req_tlast,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // data_byte, status, format_tag, channels, sample_rate, byte_rate,
   // block_align, bits_per_sample, valid_bits, channel_mask, data_length, zero pad
   output logic [223:0]      rsp_tdata,
   output logic              rsp_tuser    // kind
);

   push_type   push;
   result_type head;
   logic       accept;

   assign accept = req_tvalid & req_tready;

   wav_riff_core u_core (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .byte_in   (req_tdata),
      .last_byte (req_tlast),
      .push      (push)
   );

   wav_riff_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (req_tready),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_item  (head)
   );

   assign rsp_tuser = head.kind;
   assign rsp_tdata = {4'd0, head.data_length, head.channel_mask, head.valid_bits,
                       head.bits_per_sample, head.block_align, head.byte_rate,
                       head.sample_rate, head.channels, head.format_tag,
                       head.status, head.data_byte};

endmodule

`default_nettype wire

[rtl/wav_riff_core.sv]
`default_nettype none

module wav_riff_core
   import wav_riff_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       accept,
   input  wire logic [7:0] byte_in,
   input  wire logic       last_byte,
   output push_type        push
);

   typedef enum logic [2:0] {
      PH_RIFF, PH_WAVE, PH_HDR, PH_FMT, PH_FACT, PH_DATA, PH_PAD, PH_SKIP
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [5:0]  fc_ff, fc_in;
   logic [31:0] rem_ff, rem_in;
   logic [32:0] riff_end_ff, riff_end_in;
   logic [32:0] pos_ff, pos_in;
   logic [31:0] shift_ff, shift_in;
   logic [31:0] tag_ff, tag_in;
   logic [15:0] fmt_tag_ff, fmt_tag_in;
   logic [15:0] chans_ff, chans_in;
   logic [31:0] srate_ff, srate_in;
   logic [31:0] brate_ff, brate_in;
   logic [15:0] align_ff, align_in;
   logic [15:0] bits_ff, bits_in;
   logic [15:0] vbits_ff, vbits_in;
   logic [31:0] mask_ff, mask_in;
   logic [31:0] dlen_ff, dlen_in;
   logic [1:0]  found_ff, found_in;
   logic        finished_ff, finished_in;

   function automatic status_type flag_code(input logic [1:0] f);
      status_type c;
      unique case (f)
         2'b11:   c = ST_OK;
         2'b01:   c = ST_NO_DATA;
         2'b10:   c = ST_NO_FMT;
         default: c = ST_NEITHER;
      endcase
      return c;
   endfunction

   always_comb begin
      logic        data_emit;
      logic        status_emit;
      status_type  code;
      logic        rest_req;
      logic        done_req;
      logic [31:0] s;
      logic [15:0] v16;
      result_type  dres;
      result_type  sres;

      phase_in    = phase_ff;
      fc_in       = fc_ff;
      rem_in      = rem_ff;
      riff_end_in = riff_end_ff;
      pos_in      = pos_ff;
      shift_in    = shift_ff;
      tag_in      = tag_ff;
      fmt_tag_in  = fmt_tag_ff;
      chans_in    = chans_ff;
      srate_in    = srate_ff;
      brate_in    = brate_ff;
      align_in    = align_ff;
      bits_in     = bits_ff;
      vbits_in    = vbits_ff;
      mask_in     = mask_ff;
      dlen_in     = dlen_ff;
      found_in    = found_ff;
      finished_in = finished_ff;
      data_emit   = 1'b0;
      status_emit = 1'b0;
      code        = ST_OK;
      rest_req    = 1'b0;
      done_req    = 1'b0;
      s           = '0;
      v16         = '0;

      if (accept && !finished_ff) begin
         pos_in   = (pos_ff == '1) ? pos_ff : pos_ff + 33'd1;
         shift_in = {byte_in, shift_ff[31:8]};
         s        = shift_in;
         v16      = shift_in[31:16];
         unique case (phase_ff)
            PH_RIFF, PH_HDR: begin
               if (fc_ff < 6'd4) tag_in = {tag_ff[23:0], byte_in};
               fc_in = fc_ff + 6'd1;
               if (fc_in == 6'd8) begin
                  if (phase_ff == PH_HDR) begin
                     rem_in = s;
                     fc_in  = '0;
                     if (tag_in == TAG_FMT) begin
                        if (s < FMT_CORE_LEN) begin
                           status_emit = 1'b1;
                           code        = ST_BAD_FMT;
                        end else begin
                           vbits_in = '0;
                           mask_in  = '0;
                           phase_in = PH_FMT;
                        end
                     end else if (tag_in == TAG_FACT) begin
                        phase_in = PH_FACT;
                     end else if (tag_in == TAG_DATA) begin
                        dlen_in = s;
                        if (s == '0) begin
                           found_in = found_in | 2'b10;
                           done_req = 1'b1;
                        end else begin
                           phase_in = PH_DATA;
                        end
                     end else begin
                        rest_req = 1'b1;
                     end
                  end else if (s <= 32'd4) begin
                     status_emit = 1'b1;
                     code        = ST_SMALL;
                  end else if (tag_in != TAG_RIFF) begin
                     status_emit = 1'b1;
                     code        = ST_NO_RIFF;
                  end else begin
                     riff_end_in = {1'b0, s} + 33'd8;
                     phase_in    = PH_WAVE;
                     fc_in       = '0;
                  end
               end
            end
            PH_WAVE: begin
               tag_in = {tag_ff[23:0], byte_in};
               fc_in  = fc_ff + 6'd1;
               if (fc_in == 6'd4) begin
                  if (tag_in != TAG_WAVE) begin
                     status_emit = 1'b1;
                     code        = ST_NO_WAVE;
                  end else begin
                     done_req = 1'b1;
                  end
               end
            end
            PH_FMT: begin
               fc_in = fc_ff + 6'd1;
               if (rem_ff != '0) rem_in = rem_ff - 32'd1;
               unique case (fc_ff)
                  6'd1:  fmt_tag_in = v16;
                  6'd3:  chans_in   = v16;
                  6'd7:  srate_in   = s;
                  6'd11: brate_in   = s;
                  6'd13: align_in   = v16;
                  6'd15: begin
                     bits_in = v16;
                     if (rem_in == '0) begin
                        found_in = found_in | 2'b01;
                        done_req = 1'b1;
                     end
                  end
                  6'd17: begin
                     if (v16 == '0) begin
                        found_in = found_in | 2'b01;
                        rest_req = 1'b1;
                     end else if (v16 != EXT_SIZE) begin
                        status_emit = 1'b1;
                        code        = ST_BAD_FMT;
                     end
                  end
                  6'd19: vbits_in = v16;
                  6'd23: mask_in  = s;
                  6'd39: begin
                     found_in = found_in | 2'b01;
                     rest_req = 1'b1;
                  end
                  default: ;
               endcase
            end
            PH_FACT: begin
               if (rem_ff != '0) rem_in = rem_ff - 32'd1;
               fc_in = fc_ff + 6'd1;
               if (fc_in == 6'd4) rest_req = 1'b1;
            end
            PH_DATA: begin
               data_emit = 1'b1;
               if (rem_ff != '0) rem_in = rem_ff - 32'd1;
               if (rem_in == '0) begin
                  found_in = found_in | 2'b10;
                  if (dlen_ff[0]) phase_in = PH_PAD;
                  else            done_req = 1'b1;
               end
            end
            PH_PAD: done_req = 1'b1;
            default: begin
               if (rem_ff != '0) rem_in = rem_ff - 32'd1;
               if (rem_in == '0) done_req = 1'b1;
            end
         endcase

         if (rest_req) begin
            if (rem_in == '0) done_req = 1'b1;
            else              phase_in = PH_SKIP;
         end
         if (done_req) begin
            if ({1'b0, riff_end_ff} > {1'b0, pos_in} + TAIL_MIN) begin
               phase_in = PH_HDR;
               fc_in    = '0;
            end else begin
               status_emit = 1'b1;
               code        = flag_code(found_in);
            end
         end
         if (last_byte && !status_emit) begin
            status_emit = 1'b1;
            code        = (phase_in == PH_FACT) ? flag_code(found_in) : ST_TRUNC;
         end
         if (status_emit) finished_in = 1'b1;
      end

      dres           = '0;
      dres.kind      = KIND_DATA;
      dres.data_byte = byte_in;

      sres        = '0;
      sres.kind   = KIND_STATUS;
      sres.status = code;
      if (code == ST_OK) begin
         sres.format_tag      = fmt_tag_in;
         sres.channels        = chans_in;
         sres.sample_rate     = srate_in;
         sres.byte_rate       = brate_in;
         sres.block_align     = align_in;
         sres.bits_per_sample = bits_in;
         sres.valid_bits      = vbits_in;
         sres.channel_mask    = mask_in;
         sres.data_length     = dlen_in;
      end

      push.first_valid  = data_emit | status_emit;
      push.second_valid = data_emit & status_emit;
      push.first        = data_emit ? dres : sres;
      push.second       = sres;

      if (accept && last_byte) begin
         phase_in    = PH_RIFF;
         fc_in       = '0;
         rem_in      = '0;
         riff_end_in = '0;
         pos_in      = '0;
         shift_in    = '0;
         tag_in      = '0;
         fmt_tag_in  = '0;
         chans_in    = '0;
         srate_in    = '0;
         brate_in    = '0;
         align_in    = '0;
         bits_in     = '0;
         vbits_in    = '0;
         mask_in     = '0;
         dlen_in     = '0;
         found_in    = '0;
         finished_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_RIFF;
         fc_ff       <= '0;
         rem_ff      <= '0;
         riff_end_ff <= '0;
         pos_ff      <= '0;
         shift_ff    <= '0;
         tag_ff      <= '0;
         fmt_tag_ff  <= '0;
         chans_ff    <= '0;
         srate_ff    <= '0;
         brate_ff    <= '0;
         align_ff    <= '0;
         bits_ff     <= '0;
         vbits_ff    <= '0;
         mask_ff     <= '0;
         dlen_ff     <= '0;
         found_ff    <= '0;
         finished_ff <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         fc_ff       <= fc_in;
         rem_ff      <= rem_in;
         riff_end_ff <= riff_end_in;
         pos_ff      <= pos_in;
         shift_ff    <= shift_in;
         tag_ff      <= tag_in;
         fmt_tag_ff  <= fmt_tag_in;
         chans_ff    <= chans_in;
         srate_ff    <= srate_in;
         brate_ff    <= brate_in;
         align_ff    <= align_in;
         bits_ff     <= bits_in;
         vbits_ff    <= vbits_in;
         mask_ff     <= mask_in;
         dlen_ff     <= dlen_in;
         found_ff    <= found_in;
         finished_ff <= finished_in;
      end
   end

`ifndef ASSERT_OFF
   a_quiet_when_finished: assert property (@(posedge clock) disable iff (reset)
      finished_ff |-> !push.first_valid)
      else $error("result pushed after final status");
   a_pair_ordered: assert property (@(posedge clock) disable iff (reset)
      push.second_valid |-> (push.first_valid && push.first.kind == KIND_DATA
                             && push.second.kind == KIND_STATUS))
      else $error("two results not data then status");
   a_last_restarts: assert property (@(posedge clock) disable iff (reset)
      (accept && last_byte) |=> (phase_ff == PH_RIFF && !finished_ff && pos_ff == '0))
      else $error("parser did not restart after final byte");
`endif

endmodule

`default_nettype wire

[rtl/wav_riff_queue.sv]
`default_nettype none

module wav_riff_queue
   import wav_riff_pkg::*;
#(
   parameter int Depth = RSP_QUEUE_DEPTH
) (
   input  wire logic clock,
   input  wire logic reset,
   input  push_type  push,
   output logic      room,
   output logic      out_valid,
   input  wire logic out_ready,
   output result_type out_item
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   result_type            slot_ff [Depth];
   logic [PtrW-1:0]       wr_ff, rd_ff;
   logic [CntW-1:0]       cnt_ff;
   logic [PtrW-1:0]       wr_next, wr_in, rd_in;
   logic [CntW-1:0]       cnt_in;
   logic                  pop;

   function automatic logic [PtrW-1:0] bump(input logic [PtrW-1:0] p);
      return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
   endfunction

   assign pop       = out_valid & out_ready;
   assign out_valid = (cnt_ff != '0);
   assign out_item  = slot_ff[rd_ff];
   assign room      = (cnt_ff <= CntW'(Depth - 2));
   assign wr_next   = bump(wr_ff);

   always_comb begin
      wr_in  = wr_ff;
      if (push.first_valid)  wr_in = wr_next;
      if (push.second_valid) wr_in = bump(wr_next);
      rd_in  = pop ? bump(rd_ff) : rd_ff;
      cnt_in = cnt_ff + CntW'(push.first_valid) + CntW'(push.second_valid)
               - CntW'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.first_valid)  slot_ff[wr_ff]   <= push.first;
      if (push.second_valid) slot_ff[wr_next] <= push.second;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

`ifndef ASSERT_OFF
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CntW'(Depth))
      else $error("result queue overflow");
   a_push_needs_room: assert property (@(posedge clock) disable iff (reset)
      push.first_valid |-> room)
      else $error("push without room");
   a_second_after_first: assert property (@(posedge clock) disable iff (reset)
      push.second_valid |-> push.first_valid)
      else $error("second result pushed alone");
`endif

endmodule

`default_nettype wire

[sim/wav_riff_stream_parser_tb.sv]
`timescale 1ns / 100ps

module wav_riff_stream_parser_tb
   import wav_riff_pkg::*;
();

   localparam int DirectedCount = 29;
   localparam int RandomItems = 650;
   localparam int IdleLimit = 2000;
   localparam int DrainCycles = 16;
   localparam int FlagFmt = 0;
   localparam int FlagData = 1;

   localparam logic [31:0] TAG_LIST = 32'h4C49_5354;
   localparam logic [15:0] WAVE_FMT_PCM = 16'h0001;
   localparam logic [15:0] WAVE_FMT_FLOAT = 16'h0003;
   localparam logic [15:0] WAVE_FMT_ALAW = 16'h0006;
   localparam logic [15:0] WAVE_FMT_MULAW = 16'h0007;
   localparam logic [15:0] WAVE_FMT_EXTENSIBLE = 16'hFFFE;

   typedef enum logic [2:0] {
      PS_RIFF, PS_WAVE, PS_HDR, PS_FMT, PS_FACT, PS_DATA, PS_PAD, PS_SKIP
   } parse_phase_type;

   typedef enum logic [1:0] {CK_FMT, CK_FACT, CK_DATA, CK_OTHER} chunk_kind_type;

   typedef struct packed {
      logic       typed;
      status_type code;
      logic       last;
      logic [7:0] value;
   } stim_row_type;

   localparam stim_row_type DirectedRows [DirectedCount] = '{
      // size 0 under a bad tag
      '{1'b0, ST_OK, 1'b0, 8'h58}, '{1'b0, ST_OK, 1'b0, 8'h58},
      '{1'b0, ST_OK, 1'b0, 8'h58}, '{1'b0, ST_OK, 1'b0, 8'h58},
      '{1'b0, ST_OK, 1'b0, 8'h00}, '{1'b0, ST_OK, 1'b0, 8'h00},
      '{1'b0, ST_OK, 1'b0, 8'h00}, '{1'b1, ST_SMALL, 1'b1, 8'h00},
      // bad tag, maximum size
      '{1'b0, ST_OK, 1'b0, 8'h52}, '{1'b0, ST_OK, 1'b0, 8'h49},
      '{1'b0, ST_OK, 1'b0, 8'h46}, '{1'b0, ST_OK, 1'b0, 8'h58},
      '{1'b0, ST_OK, 1'b0, 8'hFF}, '{1'b0, ST_OK, 1'b0, 8'hFF},
      '{1'b0, ST_OK, 1'b0, 8'hFF}, '{1'b1, ST_NO_RIFF, 1'b1, 8'hFF},
      // stream of one byte
      '{1'b1, ST_TRUNC, 1'b1, 8'hFF},
      // smallest accepted size, wrong form tag
      '{1'b0, ST_OK, 1'b0, 8'h52}, '{1'b0, ST_OK, 1'b0, 8'h49},
      '{1'b0, ST_OK, 1'b0, 8'h46}, '{1'b0, ST_OK, 1'b0, 8'h46},
      '{1'b0, ST_OK, 1'b0, 8'h05}, '{1'b0, ST_OK, 1'b0, 8'h00},
      '{1'b0, ST_OK, 1'b0, 8'h00}, '{1'b0, ST_OK, 1'b0, 8'h00},
      '{1'b0, ST_OK, 1'b0, 8'h57}, '{1'b0, ST_OK, 1'b0, 8'h41},
      '{1'b0, ST_OK, 1'b0, 8'h56}, '{1'b1, ST_NO_WAVE, 1'b1, 8'h58}
   };

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [7:0]   req_tdata = 8'h00;
   logic         req_tlast = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [223:0] rsp_tdata;
   logic         rsp_tuser;

   stim_row_type cur_row = '0;
   stim_row_type stimulus [$];
   logic [7:0]   file_bytes [$];
   result_type   results_due [$];
   result_type   byte_results [$];
   int           mismatch_count = 0;
   int           idle_cycles = 0;

   parse_phase_type ph;
   logic [5:0]   fcnt;
   logic [31:0]  remain;
   logic [32:0]  span_end;
   logic [32:0]  pos;
   logic [31:0]  shreg;
   logic [31:0]  ck_tag;
   logic [15:0]  cb_size;
   logic [15:0]  f_tag, f_channels, f_align, f_bits, f_valid;
   logic [31:0]  f_rate, f_byte_rate, f_mask, data_len;
   logic [31:0]  fact_count;
   logic [1:0]   found;
   logic         done;

   wav_riff_stream_parser dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   task automatic parse_restart();
      ph = PS_RIFF;
      fcnt = '0;
      remain = '0;
      span_end = '0;
      pos = '0;
      shreg = '0;
      ck_tag = '0;
      cb_size = '0;
      f_tag = '0;
      f_channels = '0;
      f_align = '0;
      f_bits = '0;
      f_valid = '0;
      f_rate = '0;
      f_byte_rate = '0;
      f_mask = '0;
      data_len = '0;
      fact_count = '0;
      found = '0;
      done = 1'b0;
   endtask

   function automatic status_type found_code();
      case (found)
         2'b11: return ST_OK;
         2'b01: return ST_NO_DATA;
         2'b10: return ST_NO_FMT;
         default: return ST_NEITHER;
      endcase
   endfunction

   task automatic emit_status(status_type code);
      result_type r;
      r = '0;
      r.kind = KIND_STATUS;
      r.status = code;
      if (code == ST_OK) begin
         r.format_tag = f_tag;
         r.channels = f_channels;
         r.sample_rate = f_rate;
         r.byte_rate = f_byte_rate;
         r.block_align = f_align;
         r.bits_per_sample = f_bits;
         r.valid_bits = f_valid;
         r.channel_mask = f_mask;
         r.data_length = data_len;
      end
      byte_results.push_back(r);
      done = 1'b1;
   endtask

   task automatic chunk_end();
      if ({1'b0, span_end} > {1'b0, pos} + TAIL_MIN) begin
         ph = PS_HDR;
         fcnt = '0;
      end else begin
         emit_status(found_code());
      end
   endtask

   task automatic body_end();
      if (remain == 0) chunk_end();
      else ph = PS_SKIP;
   endtask

   task automatic open_body(logic [31:0] s);
      remain = s;
      fcnt = '0;
      if (ck_tag == TAG_FMT) begin
         if (s < FMT_CORE_LEN) begin
            emit_status(ST_BAD_FMT);
         end else begin
            f_valid = '0;
            f_mask = '0;
            cb_size = '0;
            ph = PS_FMT;
         end
      end else if (ck_tag == TAG_FACT) begin
         ph = PS_FACT;
      end else if (ck_tag == TAG_DATA) begin
         data_len = s;
         if (s == 0) begin
            found[FlagData] = 1'b1;
            chunk_end();
         end else begin
            ph = PS_DATA;
         end
      end else begin
         body_end();
      end
   endtask

   task automatic fmt_step();
      logic [5:0]  k;
      logic [15:0] hi;
      k = fcnt;
      hi = shreg[31:16];
      fcnt = k + 6'd1;
      if (remain != 0) remain = remain - 1;
      case (k)
         6'd1: f_tag = hi;
         6'd3: f_channels = hi;
         6'd7: f_rate = shreg;
         6'd11: f_byte_rate = shreg;
         6'd13: f_align = hi;
         6'd15: begin
            f_bits = hi;
            if (remain == 0) begin
               found[FlagFmt] = 1'b1;
               chunk_end();
            end
         end
         6'd17: begin
            cb_size = hi;
            if (hi == 0) begin
               found[FlagFmt] = 1'b1;
               body_end();
            end else if (hi != EXT_SIZE) begin
               emit_status(ST_BAD_FMT);
            end
         end
         6'd19: f_valid = hi;
         6'd23: f_mask = shreg;
         6'd39: begin
            found[FlagFmt] = 1'b1;
            body_end();
         end
         default: ;
      endcase
   endtask

   task automatic parse_file_byte(logic [7:0] b, logic is_last);
      logic [31:0] s;
      result_type  r;
      if (done) begin
         if (is_last) parse_restart();
      end else begin
         if (pos != '1) pos = pos + 1;
         shreg = {b, shreg[31:8]};
         case (ph)
            PS_RIFF, PS_HDR: begin
               if (fcnt < 4) ck_tag = {ck_tag[23:0], b};
               fcnt = fcnt + 6'd1;
               if (fcnt == 8) begin
                  s = shreg;
                  if (ph == PS_HDR) begin
                     open_body(s);
                  end else if (s <= 4) begin
                     emit_status(ST_SMALL);
                  end else if (ck_tag != TAG_RIFF) begin
                     emit_status(ST_NO_RIFF);
                  end else begin
                     span_end = {1'b0, s} + 33'd8;
                     ph = PS_WAVE;
                     fcnt = '0;
                  end
               end
            end
            PS_WAVE: begin
               ck_tag = {ck_tag[23:0], b};
               fcnt = fcnt + 6'd1;
               if (fcnt == 4) begin
                  if (ck_tag != TAG_WAVE) emit_status(ST_NO_WAVE);
                  else chunk_end();
               end
            end
            PS_FMT: fmt_step();
            PS_FACT: begin
               if (remain != 0) remain = remain - 1;
               fcnt = fcnt + 6'd1;
               if (fcnt == 4) begin
                  fact_count = shreg;
                  body_end();
               end
            end
            PS_DATA: begin
               r = '0;
               r.kind = KIND_DATA;
               r.data_byte = b;
               byte_results.push_back(r);
               if (remain != 0) remain = remain - 1;
               if (remain == 0) begin
                  found[FlagData] = 1'b1;
                  if (data_len[0]) ph = PS_PAD;
                  else chunk_end();
               end
            end
            PS_PAD: chunk_end();
            default: begin
               if (remain != 0) remain = remain - 1;
               if (remain == 0) chunk_end();
            end
         endcase
         if (is_last) begin
            if (!done) emit_status(ph == PS_FACT ? found_code() : ST_TRUNC);
            parse_restart();
         end
      end
   endtask

   function automatic string show_result(result_type r);
      return $sformatf({"kind=%0d byte=%h status=%0d tag=%h ch=%h rate=%h brate=%h",
                        " align=%h bits=%h vbits=%h mask=%h len=%h"},
                       r.kind, r.data_byte, r.status, r.format_tag, r.channels,
                       r.sample_rate, r.byte_rate, r.block_align, r.bits_per_sample,
                       r.valid_bits, r.channel_mask, r.data_length);
   endfunction

   task automatic note_mismatch(string what, result_type want, result_type got);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("%s at %0t", what, $time);
         $display("  expected %s", show_result(want));
         $display("  actual   %s", show_result(got));
      end
   endtask

   task automatic put8(logic [7:0] v);
      file_bytes.push_back(v);
   endtask

   task automatic put16(logic [15:0] v);
      put8(v[7:0]);
      put8(v[15:8]);
   endtask

   task automatic put32(logic [31:0] v);
      put16(v[15:0]);
      put16(v[31:16]);
   endtask

   task automatic put_tag(logic [31:0] t);
      put8(t[31:24]);
      put8(t[23:16]);
      put8(t[15:8]);
      put8(t[7:0]);
   endtask

   task automatic put_fill(int n);
      repeat (n) put8(8'($urandom));
   endtask

   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return $urandom;
      endcase
   endfunction

   task automatic put_chunk(chunk_kind_type k);
      int          len;
      int          wrote;
      logic [15:0] cb;
      logic [15:0] code;
      case (k)
         CK_FMT: begin
            put_tag(TAG_FMT);
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4: len = 16;
               5: len = $urandom_range(0, 15);
               default: len = $urandom_range(17, 48);
            endcase
            put32(len);
            if (len < 16) begin
               put_fill(len);
            end else begin
               case ($urandom_range(0, 5))
                  0: code = WAVE_FMT_PCM;
                  1: code = WAVE_FMT_FLOAT;
                  2: code = WAVE_FMT_ALAW;
                  3: code = WAVE_FMT_MULAW;
                  4: code = WAVE_FMT_EXTENSIBLE;
                  default: code = 16'(pick_word());
               endcase
               put16(code);
               put16(16'(pick_word()));
               put32(pick_word());
               put32(pick_word());
               put16(16'(pick_word()));
               put16(16'(pick_word()));
               if (len > 16) begin
                  case ($urandom_range(0, 6))
                     0, 1, 2: cb = '0;
                     3, 4, 5: cb = EXT_SIZE;
                     default: cb = 16'($urandom);
                  endcase
                  put16(cb);
                  wrote = 18;
                  if (cb == EXT_SIZE) begin
                     put16(16'(pick_word()));
                     put32(pick_word());
                     put_fill(16);
                     wrote = 40;
                  end
                  if ((cb == 0 || cb == EXT_SIZE) && len > wrote) put_fill(len - wrote);
               end
            end
         end
         CK_FACT: begin
            put_tag(TAG_FACT);
            len = ($urandom_range(0, 3) != 0) ? 4 : $urandom_range(0, 8);
            put32(len);
            put32($urandom);
            if (len > 4) put_fill(len - 4);
         end
         CK_DATA: begin
            put_tag(TAG_DATA);
            len = ($urandom_range(0, 7) != 0) ? $urandom_range(0, 9) : $urandom_range(10, 24);
            put32(len);
            put_fill(len + len % 2);
         end
         default: begin
            put_tag($urandom_range(0, 1) ? TAG_LIST : $urandom);
            len = $urandom_range(0, 6);
            put32(len);
            put_fill(len);
         end
      endcase
   endtask

   task automatic build_file();
      logic [31:0]  riff_len;
      logic [31:0]  cut;
      logic [31:0]  form_tag;
      logic [31:0]  less;
      stim_row_type row;
      file_bytes.delete();
      if ($urandom_range(0, 4) == 0) begin
         if ($urandom_range(0, 1)) put_tag(TAG_RIFF);
         put_fill($urandom_range(1, 10));
      end else begin
         form_tag = TAG_WAVE;
         if ($urandom_range(0, 15) == 0) form_tag = form_tag ^ (32'd1 << $urandom_range(0, 31));
         if ($urandom_range(0, 15) == 0) put_tag(TAG_RIFF ^ (32'd1 << $urandom_range(0, 31)));
         else put_tag(TAG_RIFF);
         put32('0);
         put_tag(form_tag);
         if ($urandom_range(0, 3) == 0) put_chunk(CK_OTHER);
         if ($urandom_range(0, 19) < 17) put_chunk(CK_FMT);
         if ($urandom_range(0, 9) < 3) put_chunk(CK_FACT);
         if ($urandom_range(0, 3) == 0) put_chunk(CK_OTHER);
         if ($urandom_range(0, 19) < 17) put_chunk(CK_DATA);
         if ($urandom_range(0, 9) < 3) put_chunk(chunk_kind_type'($urandom_range(0, 3)));
         riff_len = file_bytes.size() - 8;
         case ($urandom_range(0, 15))
            0: riff_len = $urandom_range(0, 6);
            1: riff_len = riff_len + $urandom_range(1, 12);
            2: begin
               less = $urandom_range(1, 12);
               riff_len = (riff_len > less) ? riff_len - less : '0;
            end
            3: riff_len = pick_word();
            default: ;
         endcase
         file_bytes[4] = riff_len[7:0];
         file_bytes[5] = riff_len[15:8];
         file_bytes[6] = riff_len[23:16];
         file_bytes[7] = riff_len[31:24];
         if ($urandom_range(0, 7) == 0) begin
            cut = $urandom_range(1, file_bytes.size() - 1);
            while (file_bytes.size() > cut) void'(file_bytes.pop_back());
         end
         if ($urandom_range(0, 7) == 0) put_fill($urandom_range(1, 6));
      end
      foreach (file_bytes[i]) begin
         row = '0;
         row.value = file_bytes[i];
         row.last = (i == file_bytes.size() - 1);
         stimulus.push_back(row);
      end
   endtask

   always @(posedge clock) begin : monitor
      result_type got;
      result_type want;
      if (!reset && req_tvalid && req_tready) begin
         byte_results.delete();
         parse_file_byte(req_tdata, req_tlast);
         if (cur_row.typed) begin
            want = '0;
            want.kind = KIND_STATUS;
            want.status = cur_row.code;
            results_due.push_back(want);
         end else begin
            foreach (byte_results[i]) results_due.push_back(byte_results[i]);
         end
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.kind = kind_type'(rsp_tuser);
         got.data_byte = rsp_tdata[7:0];
         got.status = status_type'(rsp_tdata[11:8]);
         got.format_tag = rsp_tdata[27:12];
         got.channels = rsp_tdata[43:28];
         got.sample_rate = rsp_tdata[75:44];
         got.byte_rate = rsp_tdata[107:76];
         got.block_align = rsp_tdata[123:108];
         got.bits_per_sample = rsp_tdata[139:124];
         got.valid_bits = rsp_tdata[155:140];
         got.channel_mask = rsp_tdata[187:156];
         got.data_length = rsp_tdata[219:188];
         if (results_due.size() == 0) begin
            note_mismatch("unexpected item", '0, got);
         end else begin
            want = results_due.pop_front();
            if (got.kind !== want.kind || got.data_byte !== want.data_byte ||
                got.status !== want.status || got.format_tag !== want.format_tag ||
                got.channels !== want.channels || got.sample_rate !== want.sample_rate ||
                got.byte_rate !== want.byte_rate || got.block_align !== want.block_align ||
                got.bits_per_sample !== want.bits_per_sample ||
                got.valid_bits !== want.valid_bits ||
                got.channel_mask !== want.channel_mask ||
                got.data_length !== want.data_length) begin
               note_mismatch("item mismatch", want, got);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : watchdog
      wait (idle_cycles >= IdleLimit);
      $display("TB_ERROR");
      $finish;
   end

   initial begin : receiver
      int   stall;
      logic rsp_burst;
      rsp_burst = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if ($urandom_range(0, 39) == 0) rsp_burst = !rsp_burst;
         stall = rsp_burst ? 0 : $urandom_range(0, 12);
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   initial begin : sender
      int   gap;
      int   idx;
      logic send_burst;
      parse_restart();
      foreach (DirectedRows[i]) stimulus.push_back(DirectedRows[i]);
      while (stimulus.size() < DirectedCount + RandomItems) build_file();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      send_burst = 1'b0;
      for (idx = 0; idx < stimulus.size(); idx++) begin
         if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
         // hold until the block has drained
         if (idx == DirectedCount || (idx > 0 && $urandom_range(0, 199) == 0)) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
            while (results_due.size() != 0) @(posedge clock);
         end
         gap = send_burst ? 0 : $urandom_range(0, 12);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_tvalid <= 1'b1;
         req_tdata <= stimulus[idx].value;
         req_tlast <= stimulus[idx].last;
         cur_row <= stimulus[idx];
         @(posedge clock);
         while (!req_tready) @(posedge clock);
      end
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (results_due.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

[files.f]
rtl/wav_riff_pkg.sv
rtl/wav_riff_core.sv
rtl/wav_riff_queue.sv
rtl/wav_riff_stream_parser.sv
sim/wav_riff_stream_parser_tb.sv
